FILE: hw/rtl/hsg_pkg.sv
// Shared types, constants and register map for the height stability gate.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package hsg_pkg;

  localparam int NOW_W      = 32;
  localparam int SAMPLE_W   = 13;
  localparam int HEIGHT_W   = 12;
  localparam int TOL_W      = 10;
  localparam int MS_W       = 16;
  localparam int STATUS_W   = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [SAMPLE_W-1:0] MAX_DISTANCE_MM = 13'd2000;

  localparam logic [HEIGHT_W-1:0] PILLAR_RST   = 12'd1980;
  localparam logic [HEIGHT_W-1:0] MIN_RST      = 12'd1000;
  localparam logic [HEIGHT_W-1:0] MAX_RST      = 12'd1980;
  localparam logic [TOL_W-1:0]    TOL_RST      = 10'd20;
  localparam logic [MS_W-1:0]     WINDOW_RST   = 16'd3000;
  localparam logic [MS_W-1:0]     COOLDOWN_RST = 16'd5000;

  typedef enum logic [2:0] {
    REG_PILLAR   = 3'd0,
    REG_MIN      = 3'd1,
    REG_MAX      = 3'd2,
    REG_TOL      = 3'd3,
    REG_WINDOW   = 3'd4,
    REG_COOLDOWN = 3'd5
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_COOLDOWN = 3'd0,
    ST_INVALID  = 3'd1,
    ST_START    = 3'd2,
    ST_RESET    = 3'd3,
    ST_BUILDING = 3'd4,
    ST_FIRED    = 3'd5
  } status_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] pillar;
    logic [HEIGHT_W-1:0] min_h;
    logic [HEIGHT_W-1:0] max_h;
    logic [TOL_W-1:0]    tol;
    logic [MS_W-1:0]     window;
    logic [MS_W-1:0]     cooldown;
  } cfg_t;

  // Classified tick handed from front to back
  typedef struct packed {
    logic [NOW_W-1:0]    now_ms;
    logic                ok;
    logic [HEIGHT_W-1:0] height;
  } item_t;

endpackage

FILE: hw/rtl/hsg_in_if.sv
// Input channel of the height stability gate: one tick per transfer.
// Depends on hsg_pkg for field widths.
`timescale 1ns / 1ps

interface hsg_in_if import hsg_pkg::*;;
  logic                valid;
  logic                ready;
  logic [NOW_W-1:0]    now_ms;
  logic [SAMPLE_W-1:0] sample_a_mm;
  logic [SAMPLE_W-1:0] sample_b_mm;
  logic [SAMPLE_W-1:0] sample_c_mm;
  logic                timeout_a;
  logic                timeout_b;
  logic                timeout_c;

  modport source (
    output valid, now_ms, sample_a_mm, sample_b_mm, sample_c_mm,
           timeout_a, timeout_b, timeout_c,
    input  ready
  );
  modport sink (
    input  valid, now_ms, sample_a_mm, sample_b_mm, sample_c_mm,
           timeout_a, timeout_b, timeout_c,
    output ready
  );
endinterface

FILE: hw/rtl/hsg_out_if.sv
// Result channel of the height stability gate: one result per transfer.
// Depends on hsg_pkg for field widths.
`timescale 1ns / 1ps

interface hsg_out_if import hsg_pkg::*;;
  logic                valid;
  logic                ready;
  logic                fired;
  logic [HEIGHT_W-1:0] height_mm;
  logic [STATUS_W-1:0] status;

  modport source (output valid, fired, height_mm, status, input ready);
  modport sink   (input valid, fired, height_mm, status, output ready);
endinterface

FILE: hw/rtl/hsg_cfg.sv
// APB-style register file holding the six gate settings.
// Depends on hsg_pkg for the register map and cfg_t.
`timescale 1ns / 1ps

module hsg_cfg import hsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pillar   <= PILLAR_RST;
      cfg_r.min_h    <= MIN_RST;
      cfg_r.max_h    <= MAX_RST;
      cfg_r.tol      <= TOL_RST;
      cfg_r.window   <= WINDOW_RST;
      cfg_r.cooldown <= COOLDOWN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PILLAR:   cfg_r.pillar   <= pwdata[HEIGHT_W-1:0];
        REG_MIN:      cfg_r.min_h    <= pwdata[HEIGHT_W-1:0];
        REG_MAX:      cfg_r.max_h    <= pwdata[HEIGHT_W-1:0];
        REG_TOL:      cfg_r.tol      <= pwdata[TOL_W-1:0];
        REG_WINDOW:   cfg_r.window   <= pwdata[MS_W-1:0];
        REG_COOLDOWN: cfg_r.cooldown <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PILLAR:   prdata = CFG_DATA_W'(cfg_r.pillar);
      REG_MIN:      prdata = CFG_DATA_W'(cfg_r.min_h);
      REG_MAX:      prdata = CFG_DATA_W'(cfg_r.max_h);
      REG_TOL:      prdata = CFG_DATA_W'(cfg_r.tol);
      REG_WINDOW:   prdata = CFG_DATA_W'(cfg_r.window);
      REG_COOLDOWN: prdata = CFG_DATA_W'(cfg_r.cooldown);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/hsg_front.sv
// Front stage: accepts ticks, checks the three samples and takes the median.
// Depends on hsg_pkg and hsg_in_if.
`timescale 1ns / 1ps

module hsg_front import hsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  hsg_in_if.sink      in_ch,
  output logic        item_valid,
  output item_t       item,
  input  logic        item_ready
);

  typedef struct packed {
    logic                ok;
    logic [HEIGHT_W-1:0] h;
  } lane_t;

  function automatic lane_t check_lane(input logic [SAMPLE_W-1:0] range_mm,
                                       input logic tmo, input cfg_t c);
    logic signed [HEIGHT_W+1:0] v;
    lane_t r;
    // height can go negative when the sample exceeds the pillar
    v    = $signed({2'b00, c.pillar}) - $signed({1'b0, range_mm});
    r.ok = !tmo && (range_mm != '0) && (range_mm <= MAX_DISTANCE_MM) &&
           (v >= $signed({2'b00, c.min_h})) && (v <= $signed({2'b00, c.max_h}));
    r.h  = v[HEIGHT_W-1:0];
    return r;
  endfunction

  function automatic logic [HEIGHT_W-1:0] median3(input logic [HEIGHT_W-1:0] a,
                                                  input logic [HEIGHT_W-1:0] b,
                                                  input logic [HEIGHT_W-1:0] c);
    logic [HEIGHT_W-1:0] lo;
    logic [HEIGHT_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    else if (c >= hi) return hi;
    else return c;
  endfunction

  logic  front_valid_r;
  item_t item_r;
  item_t item_nxt;
  lane_t la, lb, lc;

  always_comb begin
    la = check_lane(in_ch.sample_a_mm, in_ch.timeout_a, cfg);
    lb = check_lane(in_ch.sample_b_mm, in_ch.timeout_b, cfg);
    lc = check_lane(in_ch.sample_c_mm, in_ch.timeout_c, cfg);
    item_nxt.now_ms = in_ch.now_ms;
    item_nxt.ok     = la.ok && lb.ok && lc.ok;
    item_nxt.height = median3(la.h, lb.h, lc.h);
  end

  // advance whenever the queue takes the held item or nothing is held
  assign in_ch.ready = !front_valid_r || item_ready;
  assign item_valid  = front_valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      front_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: hw/rtl/hsg_queue.sv
// Short FIFO of classified ticks between front and back stages.
// Depends on hsg_pkg for item_t.
`timescale 1ns / 1ps

module hsg_queue import hsg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  item_t            mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/hsg_back.sv
// Back stage: cooldown test, stability window and the result register.
// Depends on hsg_pkg and hsg_out_if.
`timescale 1ns / 1ps

module hsg_back import hsg_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   pop_valid,
  output logic   pop_ready,
  input  item_t  pop_data,
  hsg_out_if.source out_ch
);

  logic                  win_active_r, win_active_nxt;
  logic [HEIGHT_W-1:0]   anchor_r, anchor_nxt;
  logic [TIME_WIDTH-1:0] start_r, start_nxt;
  logic [TIME_WIDTH-1:0] cool_until_r, cool_until_nxt;
  logic                  out_valid_r;
  logic                  fired_r, fired_nxt;
  logic [HEIGHT_W-1:0]   height_r, height_nxt;
  status_t               status_r, status_nxt;

  logic                  take;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [HEIGHT_W-1:0]   dev;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign take      = pop_valid && pop_ready;
  assign now_t     = TIME_WIDTH'(pop_data.now_ms);
  assign elapsed   = now_t - start_r;
  assign dev       = (pop_data.height >= anchor_r) ? pop_data.height - anchor_r
                                                   : anchor_r - pop_data.height;

  always_comb begin
    win_active_nxt = win_active_r;
    anchor_nxt     = anchor_r;
    start_nxt      = start_r;
    cool_until_nxt = cool_until_r;
    fired_nxt      = 1'b0;
    height_nxt     = '0;
    if (now_t < cool_until_r) begin
      status_nxt = ST_COOLDOWN;
    end else if (!pop_data.ok) begin
      status_nxt = ST_INVALID;
    end else if (!win_active_r || (dev > HEIGHT_W'(cfg.tol))) begin
      // anchor a fresh window on this height
      status_nxt     = win_active_r ? ST_RESET : ST_START;
      anchor_nxt     = pop_data.height;
      start_nxt      = now_t;
      win_active_nxt = 1'b1;
    end else if (elapsed >= TIME_WIDTH'(cfg.window)) begin
      status_nxt     = ST_FIRED;
      fired_nxt      = 1'b1;
      height_nxt     = anchor_r;
      cool_until_nxt = now_t + TIME_WIDTH'(cfg.cooldown);
      anchor_nxt     = '0;
      start_nxt      = '0;
      win_active_nxt = 1'b0;
    end else begin
      status_nxt = ST_BUILDING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_active_r <= 1'b0;
      anchor_r     <= '0;
      start_r      <= '0;
      cool_until_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        win_active_r <= win_active_nxt;
        anchor_r     <= anchor_nxt;
        start_r      <= start_nxt;
        cool_until_r <= cool_until_nxt;
      end
      if (pop_ready) out_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fired_r  <= fired_nxt;
      height_r <= height_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.fired     = fired_r;
  assign out_ch.height_mm = height_r;
  assign out_ch.status    = status_r;

endmodule

FILE: hw/rtl/height_stability_gate.sv
// Top level of the height stability gate: register file, front, queue, back.
// Depends on hsg_pkg, hsg_in_if, hsg_out_if and the hsg_* modules.
//
//  channel   direction  handshake            payload
//  in_ch     in         valid/ready          now_ms, sample_{a,b,c}_mm, timeout_{a,b,c}
//  out_ch    out        valid/ready          fired, height_mm, status
//  cfg_*     in         APB write/read       six settings at byte address 4*i
//
// One tick per cycle while out_ch is ready; a result passes the front register, a queue
// entry and the result register before it is valid on out_ch.
// rst_n is synchronous: it clears the gate state and restores register defaults.
// The front keeps taking ticks while a result waits, until the queue fills.
`timescale 1ns / 1ps

module height_stability_gate import hsg_pkg::*; #(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hsg_in_if.sink                in_ch,
  hsg_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t  cfg;
  logic  push_valid, push_ready;
  item_t push_data;
  logic  pop_valid, pop_ready;
  item_t pop_data;

  hsg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  hsg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .item_valid (push_valid),
    .item       (push_data),
    .item_ready (push_ready)
  );

  hsg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hsg_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

FILE: verif/tb_height_stability_gate.sv
// Self-checking testbench for height_stability_gate: a table of opening ticks,
// then random tick streams under several register settings.
// Depends on hsg_pkg, hsg_in_if, hsg_out_if and the RTL top level.
`timescale 1ns / 1ps

module tb_height_stability_gate import hsg_pkg::*;;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    logic [NOW_W-1:0]    now_ms;
    logic [SAMPLE_W-1:0] sample_a_mm;
    logic [SAMPLE_W-1:0] sample_b_mm;
    logic [SAMPLE_W-1:0] sample_c_mm;
    logic                timeout_a;
    logic                timeout_b;
    logic                timeout_c;
  } tick_t;

  typedef struct packed {
    logic                fired;
    logic [HEIGHT_W-1:0] height;
    status_t             status;
  } outcome_t;

  typedef struct packed {
    tick_t    t;
    logic     typed;
    outcome_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  hsg_in_if  in_ch ();
  hsg_out_if out_ch ();

  height_stability_gate dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Gate model state and settings
  cfg_t                gate_cfg;
  logic                win_open;
  logic [HEIGHT_W-1:0] win_anchor;
  logic [NOW_W-1:0]    win_start;
  logic [NOW_W-1:0]    cool_until;

  outcome_t      pending_outcomes[$];
  script_row_t   opening_script[$];
  int            errors;
  int            ticks_sent;
  int            results_seen;
  int            status_tally[6];
  int            settings_used;
  int            quiet_cycles;
  int            burst_left;
  bit            sender_quiet;
  bit            sink_quiet;
  bit            hold_req;
  logic [NOW_W-1:0] clock_ms;
  int            target_h;

  task automatic flag_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic bit height_from_range(logic [SAMPLE_W-1:0] range_mm, logic tmo,
                                           output int h);
    h = int'(gate_cfg.pillar) - int'(range_mm);
    if (tmo || range_mm == '0 || range_mm > MAX_DISTANCE_MM) return 1'b0;
    return h >= int'(gate_cfg.min_h) && h <= int'(gate_cfg.max_h);
  endfunction

  // Work out the result of one tick and advance the gate state
  function automatic outcome_t predict_gate_outcome(tick_t t);
    outcome_t         o;
    int               ha, hb, hc, lo, hi, h, dev;
    bit               ok;
    logic [NOW_W-1:0] age;
    o.fired  = 1'b0;
    o.height = '0;
    if (t.now_ms < cool_until) begin
      o.status = ST_COOLDOWN;
      return o;
    end
    ok = height_from_range(t.sample_a_mm, t.timeout_a, ha) &&
         height_from_range(t.sample_b_mm, t.timeout_b, hb) &&
         height_from_range(t.sample_c_mm, t.timeout_c, hc);
    if (!ok) begin
      o.status = ST_INVALID;
      return o;
    end
    lo = (ha < hb) ? ha : hb;
    hi = (ha < hb) ? hb : ha;
    h  = (hc <= lo) ? lo : (hc >= hi) ? hi : hc;
    if (!win_open) begin
      win_anchor = h[HEIGHT_W-1:0];
      win_start  = t.now_ms;
      win_open   = 1'b1;
      o.status   = ST_START;
      return o;
    end
    dev = h - int'(win_anchor);
    if (dev < 0) dev = -dev;
    if (dev > int'(gate_cfg.tol)) begin
      win_anchor = h[HEIGHT_W-1:0];
      win_start  = t.now_ms;
      o.status   = ST_RESET;
      return o;
    end
    age = t.now_ms - win_start;
    if (age >= NOW_W'(gate_cfg.window)) begin
      o.fired    = 1'b1;
      o.height   = win_anchor;
      o.status   = ST_FIRED;
      cool_until = t.now_ms + NOW_W'(gate_cfg.cooldown);
      win_anchor = '0;
      win_start  = '0;
      win_open   = 1'b0;
      return o;
    end
    o.status = ST_BUILDING;
    return o;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] cfg_field(cfg_t c, reg_idx_t r);
    case (r)
      REG_PILLAR:   return CFG_DATA_W'(c.pillar);
      REG_MIN:      return CFG_DATA_W'(c.min_h);
      REG_MAX:      return CFG_DATA_W'(c.max_h);
      REG_TOL:      return CFG_DATA_W'(c.tol);
      REG_WINDOW:   return CFG_DATA_W'(c.window);
      REG_COOLDOWN: return CFG_DATA_W'(c.cooldown);
      default:      return '0;
    endcase
  endfunction

  // One APB transfer: setup, access, then release
  task automatic cfg_access(bit wr, reg_idx_t r, logic [CFG_DATA_W-1:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (wr) begin
      case (r)
        REG_PILLAR:   gate_cfg.pillar   = wdata[HEIGHT_W-1:0];
        REG_MIN:      gate_cfg.min_h    = wdata[HEIGHT_W-1:0];
        REG_MAX:      gate_cfg.max_h    = wdata[HEIGHT_W-1:0];
        REG_TOL:      gate_cfg.tol      = wdata[TOL_W-1:0];
        REG_WINDOW:   gate_cfg.window   = wdata[MS_W-1:0];
        REG_COOLDOWN: gate_cfg.cooldown = wdata[MS_W-1:0];
        default: ;
      endcase
    end else if (cfg_prdata !== cfg_field(gate_cfg, r)) begin
      flag_mismatch($sformatf("readback of register %s", r.name()),
                    cfg_prdata, cfg_field(gate_cfg, r));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and let the pipeline empty out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t c);
    int k;
    wait_drained();
    for (k = 0; k < 6; k++) cfg_access(1'b1, reg_idx_t'(k), cfg_field(c, reg_idx_t'(k)));
    for (k = 0; k < 6; k++) cfg_access(1'b0, reg_idx_t'(k), '0);
    settings_used++;
  endtask

  task automatic offer_tick(tick_t t, logic typed, outcome_t want);
    int       gap;
    outcome_t got;
    gap = (burst_left > 0 || sender_quiet) ? 0 : $urandom_range(0, 5);
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.now_ms      <= t.now_ms;
    in_ch.sample_a_mm <= t.sample_a_mm;
    in_ch.sample_b_mm <= t.sample_b_mm;
    in_ch.sample_c_mm <= t.sample_c_mm;
    in_ch.timeout_a   <= t.timeout_a;
    in_ch.timeout_b   <= t.timeout_b;
    in_ch.timeout_c   <= t.timeout_c;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    ticks_sent++;
    got = predict_gate_outcome(t);
    if (typed && got != want) begin
      flag_mismatch("table row disagrees with gate model", got.status, want.status);
      got = want;
    end
    pending_outcomes.push_back(got);
  endtask

  task automatic add_row(logic [NOW_W-1:0] now, int a, int b, int c, logic [2:0] tmo,
                         logic typed, status_t st, int h);
    script_row_t row;
    row.t.now_ms      = now;
    row.t.sample_a_mm = SAMPLE_W'(a);
    row.t.sample_b_mm = SAMPLE_W'(b);
    row.t.sample_c_mm = SAMPLE_W'(c);
    {row.t.timeout_a, row.t.timeout_b, row.t.timeout_c} = tmo;
    row.typed       = typed;
    row.want.fired  = (st == ST_FIRED);
    row.want.height = HEIGHT_W'(h);
    row.want.status = st;
    opening_script.push_back(row);
  endtask

  // Pick a height that all three samples can reach under the current settings, or any height if none can
  task automatic pick_target();
    int lo, hi;
    lo = int'(gate_cfg.pillar) - 2000;
    if (lo < int'(gate_cfg.min_h)) lo = int'(gate_cfg.min_h);
    hi = int'(gate_cfg.pillar) - 1;
    if (hi > int'(gate_cfg.max_h)) hi = int'(gate_cfg.max_h);
    target_h = (lo > hi) ? int'($urandom_range(0, 4095)) : int'($urandom_range(lo, hi));
  endtask

  function automatic logic [SAMPLE_W-1:0] aim_distance(int spread);
    int d;
    d = int'(gate_cfg.pillar) - target_h + int'($urandom_range(0, 2 * spread)) - spread;
    if (d < 0) d = 0;
    if (d > 8191) d = 8191;
    return SAMPLE_W'(d);
  endfunction

  task automatic random_tick(int step_max, output tick_t t);
    int kind, roll, spread, how;
    logic [SAMPLE_W-1:0] bad;
    kind = $urandom_range(0, 99);
    roll = $urandom_range(0, 99);
    if (roll < 2)      clock_ms = $urandom;
    else if (roll < 3) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    else               clock_ms = clock_ms + $urandom_range(0, step_max);
    t.now_ms = clock_ms;
    if (kind < 5) begin
      t.sample_a_mm = SAMPLE_W'($urandom);
      t.sample_b_mm = SAMPLE_W'($urandom);
      t.sample_c_mm = SAMPLE_W'($urandom);
      {t.timeout_a, t.timeout_b, t.timeout_c} = 3'($urandom);
      return;
    end
    if (kind < 12) pick_target();
    spread = ($urandom_range(0, 3) == 0) ? 0 : int'(gate_cfg.tol) / 2;
    t.sample_a_mm = aim_distance(spread);
    t.sample_b_mm = aim_distance(spread);
    t.sample_c_mm = aim_distance(spread);
    {t.timeout_a, t.timeout_b, t.timeout_c} = 3'b000;
    if (kind >= 12 && kind < 22) begin
      // spoil one lane: timeout, zero, out of range or anything at all
      how = $urandom_range(0, 3);
      bad = (how == 1) ? '0 : (how == 2) ? SAMPLE_W'($urandom_range(2001, 8191))
                                         : SAMPLE_W'($urandom);
      case ($urandom_range(0, 2))
        0: if (how == 0) t.timeout_a = 1'b1; else t.sample_a_mm = bad;
        1: if (how == 0) t.timeout_b = 1'b1; else t.sample_b_mm = bad;
        default: if (how == 0) t.timeout_c = 1'b1; else t.sample_c_mm = bad;
      endcase
    end
  endtask

  task automatic run_random(int n, bit squeeze);
    int    i, step_max;
    tick_t t;
    step_max = int'(gate_cfg.window) / 8 + 40;
    pick_target();
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      if (squeeze && i == 40) begin
        hold_req   = 1'b1;
        burst_left = 30;
      end
      if (squeeze && i == 120) wait_drained();
      random_tick(step_max, t);
      offer_tick(t, 1'b0, '0);
    end
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.pillar   = HEIGHT_W'($urandom_range(1200, 4095));
    c.min_h    = HEIGHT_W'($urandom_range(0, c.pillar / 2));
    c.max_h    = HEIGHT_W'($urandom_range(c.min_h, 4095));
    c.tol      = TOL_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 60));
    c.window   = MS_W'($urandom_range(0, 4000));
    c.cooldown = MS_W'($urandom_range(0, 6000));
    return c;
  endfunction

  // Result checker
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (out_ch.status < 6) status_tally[out_ch.status]++;
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("result with nothing pending, status", out_ch.status, -1);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ch.fired !== want.fired)
          flag_mismatch($sformatf("fired, result %0d", results_seen), out_ch.fired, want.fired);
        if (out_ch.height_mm !== want.height)
          flag_mismatch($sformatf("height_mm, result %0d", results_seen),
                        out_ch.height_mm, want.height);
        if (out_ch.status !== want.status)
          flag_mismatch($sformatf("status, result %0d", results_seen),
                        out_ch.status, want.status);
      end
    end
  end

  // Watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || cfg_psel === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a transfer", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result receiver: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int stall, taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = sink_quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      taken++;
      if (taken % 40 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    int   k;
    cfg_t c;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.now_ms      <= '0;
    in_ch.sample_a_mm <= '0;
    in_ch.sample_b_mm <= '0;
    in_ch.sample_c_mm <= '0;
    in_ch.timeout_a   <= 1'b0;
    in_ch.timeout_b   <= 1'b0;
    in_ch.timeout_c   <= 1'b0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    errors = 0;
    ticks_sent = 0;
    results_seen = 0;
    settings_used = 1;
    quiet_cycles = 0;
    burst_left = 0;
    sender_quiet = 1'b0;
    sink_quiet = 1'b0;
    hold_req = 1'b0;
    foreach (status_tally[k]) status_tally[k] = 0;

    gate_cfg.pillar   = PILLAR_RST;
    gate_cfg.min_h    = MIN_RST;
    gate_cfg.max_h    = MAX_RST;
    gate_cfg.tol      = TOL_RST;
    gate_cfg.window   = WINDOW_RST;
    gate_cfg.cooldown = COOLDOWN_RST;
    win_open   = 1'b0;
    win_anchor = '0;
    win_start  = '0;
    cool_until = '0;

    // Opening ticks under the reset settings
    add_row(100,         500,  500,  500, 3'b000, 1'b1, ST_START,    0);
    add_row(150,         500,  500,  500, 3'b100, 1'b1, ST_INVALID,  0);
    add_row(160,         500,  500,  500, 3'b010, 1'b1, ST_INVALID,  0);
    add_row(170,         500,  500,  500, 3'b001, 1'b1, ST_INVALID,  0);
    add_row(180,           0,  500,  500, 3'b000, 1'b1, ST_INVALID,  0);
    add_row(190,         500, 2001,  500, 3'b000, 1'b1, ST_INVALID,  0);
    add_row(200,         500,  500, 8191, 3'b000, 1'b1, ST_INVALID,  0);
    add_row(210,        1981,  500,  500, 3'b000, 1'b1, ST_INVALID,  0);
    add_row(220,         981,  500,  500, 3'b000, 1'b1, ST_INVALID,  0);
    add_row(230,           1,  980,  500, 3'b000, 1'b0, ST_BUILDING, 0);
    add_row(300,         505,  490,  510, 3'b000, 1'b0, ST_BUILDING, 0);
    add_row(400,         530,  530,  530, 3'b000, 1'b1, ST_RESET,    0);
    add_row(420,         510,  510,  510, 3'b000, 1'b0, ST_BUILDING, 0);
    add_row(3399,        530,  530,  530, 3'b000, 1'b0, ST_BUILDING, 0);
    add_row(3400,        530,  530,  530, 3'b000, 1'b1, ST_FIRED,    1450);
    add_row(8399,          0,    0,    0, 3'b111, 1'b1, ST_COOLDOWN, 0);
    add_row(8400,        500,  500,  500, 3'b000, 1'b1, ST_START,    0);
    add_row(8400,        500,  500,  500, 3'b000, 1'b0, ST_BUILDING, 0);
    add_row(32'hFFFFFFFF, 500, 500,  500, 3'b000, 1'b0, ST_FIRED,    0);
    add_row(10,          500,  500,  500, 3'b000, 1'b0, ST_COOLDOWN, 0);
    add_row(4999,        500,  500,  500, 3'b000, 1'b0, ST_START,    0);
    add_row(32'hFFFFF000, 500, 500,  500, 3'b000, 1'b0, ST_FIRED,    0);
    add_row(32'hFFFFF001, 500, 500,  500, 3'b000, 1'b0, ST_START,    0);
    add_row(0,           500,  500,  500, 3'b000, 1'b0, ST_COOLDOWN, 0);
    add_row(1000,        500,  500,  500, 3'b000, 1'b0, ST_FIRED,    0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values first
    for (k = 0; k < 6; k++) cfg_access(1'b0, reg_idx_t'(k), '0);

    foreach (opening_script[k])
      offer_tick(opening_script[k].t, opening_script[k].typed, opening_script[k].want);
    clock_ms = 2000;
    run_random(200, 1'b0);

    // Widest ranges, no tolerance, zero window and no cooldown
    c.pillar = 4095; c.min_h = 0; c.max_h = 4095;
    c.tol = 0; c.window = 0; c.cooldown = 0;
    apply_settings(c);
    run_random(200, 1'b0);

    // Nothing can pass: min above max with a zero pillar
    c.pillar = 0; c.min_h = 4095; c.max_h = 0;
    c.tol = 1023; c.window = 16'hFFFF; c.cooldown = 16'hFFFF;
    apply_settings(c);
    run_random(60, 1'b0);

    apply_settings(random_settings());
    run_random(200, 1'b1);
    apply_settings(random_settings());
    run_random(200, 1'b0);
    apply_settings(random_settings());
    run_random(200, 1'b0);

    // Longest window and cooldown with loose tolerance
    c.pillar = 2500; c.min_h = 500; c.max_h = 2500;
    c.tol = 1023; c.window = 16'hFFFF; c.cooldown = 16'hFFFF;
    apply_settings(c);
    run_random(200, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Covered %0d ticks and %0d results over %0d register settings",
             ticks_sent, results_seen, settings_used);
    $display("Outcomes: cooldown %0d, invalid %0d, start %0d, reset %0d, building %0d, fired %0d",
             status_tally[ST_COOLDOWN], status_tally[ST_INVALID], status_tally[ST_START],
             status_tally[ST_RESET], status_tally[ST_BUILDING], status_tally[ST_FIRED]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/hsg_pkg.sv
hw/rtl/hsg_in_if.sv
hw/rtl/hsg_out_if.sv
hw/rtl/hsg_cfg.sv
hw/rtl/hsg_front.sv
hw/rtl/hsg_queue.sv
hw/rtl/hsg_back.sv
hw/rtl/height_stability_gate.sv
verif/tb_height_stability_gate.sv
